// ===== hw/rtl/ebf_pkg.sv =====
// Shared types, constants and the tick microprogram of the eased brightness fader.
// Used by ebf_tick_engine and eased_brightness_fader; no other dependencies.
`default_nettype none

package ebf_pkg;

  // Fraction bits of the fade position and easing arithmetic
  localparam int FRACTION_BITS = 16;
  // Signed datapath width: holds magnitudes below 4.0 in Q2.F
  localparam int DW = FRACTION_BITS + 3;
  // Multiplier operand magnitude width
  localparam int MW = DW - 1;
  localparam int CNT_W = $clog2(FRACTION_BITS);
  localparam int PC_W = 4;

  localparam logic [FRACTION_BITS:0] ONE_Q = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic signed [DW:0] ONE_EXT = {{(DW - FRACTION_BITS){1'b0}}, ONE_Q};
  localparam logic signed [DW:0] LVL_MAX = (DW + 1)'(255);

  // Polynomial constants in Q2.30
  localparam longint Q30_C1 = 64'sd1073100875;
  localparam longint Q30_C2 = -64'sd532125746;
  localparam longint Q30_C3 = 64'sd39504766;
  localparam longint Q30_HALF_PI = 64'sd1686629717;

  // Round a Q2.30 constant to nearest in Q2.F, ties away from zero
  function automatic longint to_qf(input longint q30);
    longint mag;
    mag = (q30 < 0) ? -q30 : q30;
    mag = (mag + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
    return (q30 < 0) ? -mag : mag;
  endfunction

  localparam logic signed [DW-1:0] C1_Q = DW'(to_qf(Q30_C1));
  localparam logic signed [DW-1:0] C2_Q = DW'(to_qf(Q30_C2));
  localparam logic signed [DW-1:0] C3_Q = DW'(to_qf(Q30_C3));
  localparam logic signed [DW-1:0] HALF_PI_Q = DW'(to_qf(Q30_HALF_PI));

  // percent*255+50 divided by 100 through a reciprocal
  localparam logic [15:0] RECIP_100 = 16'd41944;
  localparam int RECIP_SHIFT = 22;
  localparam logic [14:0] ROUND_HALF = 15'd50;

  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

  typedef enum logic {
    CMD_SET  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SLOW_FADE = 2'd0,
    REG_FAST_FADE = 2'd1,
    REG_TICK_PER  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    cmd_t       command;
    logic [6:0] percent;
    logic       slow;
  } in_item_t;

  typedef struct packed {
    logic [7:0] level;
    logic       fade_done;
  } out_item_t;

  // Fade context handed to the engine for one tick
  typedef struct packed {
    logic [15:0] elapsed;
    logic [15:0] dur;
    logic [7:0]  start_lvl;
    logic [7:0]  target_lvl;
    logic        done;
    logic        dim;
  } job_t;

  typedef struct packed {
    logic       fin;
    logic [7:0] level;
  } eng_res_t;

  // Microcode fields
  typedef enum logic [2:0] {
    OP_NOP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL,
    OP_ADD_INNER,
    OP_EASE,
    OP_FINISH
  } uop_t;

  typedef enum logic [1:0] {
    MA_U,
    MA_X,
    MA_X2,
    MA_DELTA
  } ma_sel_t;

  typedef enum logic [2:0] {
    MB_HALF_PI,
    MB_X,
    MB_C3,
    MB_SUM,
    MB_EASED
  } mb_sel_t;

  typedef enum logic [1:0] {
    DST_X,
    DST_X2,
    DST_Y
  } dst_t;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_DONE,
    JC_CNT,
    JC_END
  } jcond_t;

  typedef struct packed {
    uop_t             op;
    ma_sel_t          ma;
    mb_sel_t          mb;
    dst_t             dst;
    jcond_t           jc;
    logic [PC_W-1:0]  target;
  } uword_t;

  // Program addresses
  localparam logic [PC_W-1:0] UA_ENTRY    = PC_W'(0);
  localparam logic [PC_W-1:0] UA_DIV_STEP = PC_W'(1);
  localparam logic [PC_W-1:0] UA_POLY     = PC_W'(2);

  // Tick program: divide, scale by pi/2, square, cosine polynomial, ease, blend
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t uw;
    case (pc)
      PC_W'(0): uw = '{OP_DIV_INIT,  MA_U,     MB_HALF_PI, DST_Y,  JC_DONE, UA_POLY};
      PC_W'(1): uw = '{OP_DIV_STEP,  MA_U,     MB_HALF_PI, DST_Y,  JC_CNT,  UA_DIV_STEP};
      PC_W'(2): uw = '{OP_MUL,       MA_U,     MB_HALF_PI, DST_X,  JC_NEXT, UA_ENTRY};
      PC_W'(3): uw = '{OP_MUL,       MA_X,     MB_X,       DST_X2, JC_NEXT, UA_ENTRY};
      PC_W'(4): uw = '{OP_MUL,       MA_X2,    MB_C3,      DST_Y,  JC_NEXT, UA_ENTRY};
      PC_W'(5): uw = '{OP_ADD_INNER, MA_U,     MB_HALF_PI, DST_Y,  JC_NEXT, UA_ENTRY};
      PC_W'(6): uw = '{OP_MUL,       MA_X2,    MB_SUM,     DST_Y,  JC_NEXT, UA_ENTRY};
      PC_W'(7): uw = '{OP_EASE,      MA_U,     MB_HALF_PI, DST_Y,  JC_NEXT, UA_ENTRY};
      PC_W'(8): uw = '{OP_MUL,       MA_DELTA, MB_EASED,   DST_Y,  JC_NEXT, UA_ENTRY};
      PC_W'(9): uw = '{OP_FINISH,    MA_U,     MB_HALF_PI, DST_Y,  JC_END,  UA_ENTRY};
      default:  uw = '{OP_NOP,       MA_U,     MB_HALF_PI, DST_Y,  JC_END,  UA_ENTRY};
    endcase
    return uw;
  endfunction

  // Magnitude of a signed datapath value
  function automatic logic [MW-1:0] mag_of(input logic signed [DW-1:0] v);
    logic [DW-1:0] m;
    m = v[DW-1] ? -v : v;
    return m[MW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ebf_tick_engine.sv =====
// Microcoded tick engine: step counter, control store from ebf_pkg, divider and
// a shared sign-magnitude multiplier. Depends on ebf_pkg.
`default_nettype none

module ebf_tick_engine
  import ebf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire job_t     job,
  input  wire logic     out_free,
  output logic          busy,
  output eng_res_t      res
);

  logic [PC_W-1:0]          pc_r, pc_nxt;
  logic                     busy_r, busy_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [15:0]              rem_r, rem_nxt;
  logic [FRACTION_BITS:0]   quo_r, quo_nxt;
  logic signed [DW-1:0]     x_r, x_nxt;
  logic signed [DW-1:0]     x2_r, x2_nxt;
  logic signed [DW-1:0]     y_r, y_nxt;
  logic signed [DW-1:0]     s_r, s_nxt;
  logic [FRACTION_BITS:0]   e_r, e_nxt;

  uword_t                   uw;
  logic                     hold;
  logic [FRACTION_BITS:0]   u_val;
  logic signed [8:0]        delta;
  logic signed [DW-1:0]     op_a, op_b;
  logic [2*MW-1:0]          prod;
  logic [MW-1:0]            prod_trunc;
  logic signed [DW-1:0]     mul_res;
  logic [16:0]              rem_dbl;
  logic                     rem_ge;
  logic signed [DW:0]       cos_s, ease_s, lvl_s;
  logic [7:0]               lvl;

  assign uw   = ucode(pc_r);
  assign hold = (uw.op == OP_FINISH) && !out_free;

  // Operand selection
  always_comb begin
    u_val = job.dim ? quo_r : (ONE_Q - quo_r);
    delta = $signed({1'b0, job.target_lvl}) - $signed({1'b0, job.start_lvl});
    case (uw.ma)
      MA_U:     op_a = $signed({{(DW - FRACTION_BITS - 1){1'b0}}, u_val});
      MA_X:     op_a = x_r;
      MA_X2:    op_a = x2_r;
      MA_DELTA: op_a = $signed({{(DW - 9){delta[8]}}, delta});
      default:  op_a = x_r;
    endcase
    case (uw.mb)
      MB_HALF_PI: op_b = HALF_PI_Q;
      MB_X:       op_b = x_r;
      MB_C3:      op_b = C3_Q;
      MB_SUM:     op_b = s_r;
      MB_EASED:   op_b = $signed({{(DW - FRACTION_BITS - 1){1'b0}}, e_r});
      default:    op_b = HALF_PI_Q;
    endcase
  end

  // Product scaled by 2^-F, truncated toward zero
  always_comb begin
    prod       = mag_of(op_a) * mag_of(op_b);
    prod_trunc = prod[FRACTION_BITS +: MW];
    mul_res    = (op_a[DW-1] ^ op_b[DW-1]) ? -$signed({1'b0, prod_trunc})
                                           : $signed({1'b0, prod_trunc});
  end

  // Restoring divider step
  always_comb begin
    rem_dbl = {rem_r, 1'b0};
    rem_ge  = rem_dbl >= {1'b0, job.dur};
  end

  // Easing: dim uses 1-cos, brighten uses cos; clamp to [0, 1]. Blended level clamps to [0, 255]
  always_comb begin
    cos_s  = $signed({C1_Q[DW-1], C1_Q}) + $signed({y_r[DW-1], y_r});
    ease_s = job.dim ? (ONE_EXT - cos_s) : cos_s;
    lvl_s  = $signed({{(DW - 7){1'b0}}, job.start_lvl}) + $signed({y_r[DW-1], y_r});
    if (lvl_s[DW]) begin
      lvl = 8'd0;
    end else if (lvl_s > LVL_MAX) begin
      lvl = 8'hFF;
    end else begin
      lvl = lvl_s[7:0];
    end
  end

  // Datapath register updates
  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    x_nxt   = x_r;
    x2_nxt  = x2_r;
    y_nxt   = y_r;
    s_nxt   = s_r;
    e_nxt   = e_r;
    if (busy_r) begin
      case (uw.op)
        OP_DIV_INIT: begin
          rem_nxt = job.elapsed;
          quo_nxt = job.done ? ONE_Q : '0;
          cnt_nxt = CNT_W'(FRACTION_BITS - 1);
        end
        OP_DIV_STEP: begin
          rem_nxt = rem_ge ? 16'(rem_dbl - {1'b0, job.dur}) : rem_dbl[15:0];
          quo_nxt = {quo_r[FRACTION_BITS-1:0], rem_ge};
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        OP_MUL: begin
          case (uw.dst)
            DST_X:   x_nxt  = mul_res;
            DST_X2:  x2_nxt = mul_res;
            DST_Y:   y_nxt  = mul_res;
            default: y_nxt  = mul_res;
          endcase
        end
        OP_ADD_INNER: begin
          s_nxt = C2_Q + y_r;
        end
        OP_EASE: begin
          if (ease_s[DW]) begin
            e_nxt = '0;
          end else if (ease_s > ONE_EXT) begin
            e_nxt = ONE_Q;
          end else begin
            e_nxt = ease_s[FRACTION_BITS:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer: step counter and conditional jumps
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (start) begin
        pc_nxt   = UA_ENTRY;
        busy_nxt = 1'b1;
      end
    end else if (!hold) begin
      case (uw.jc)
        JC_NEXT: pc_nxt = pc_r + PC_W'(1);
        JC_DONE: pc_nxt = job.done ? uw.target : pc_r + PC_W'(1);
        JC_CNT:  pc_nxt = (cnt_r != '0) ? uw.target : pc_r + PC_W'(1);
        JC_END: begin
          pc_nxt   = UA_ENTRY;
          busy_nxt = 1'b0;
        end
        default: pc_nxt = UA_ENTRY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= UA_ENTRY;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    x_r   <= x_nxt;
    x2_r  <= x2_nxt;
    y_r   <= y_nxt;
    s_r   <= s_nxt;
    e_r   <= e_nxt;
  end

  assign busy      = busy_r;
  assign res.fin   = busy_r && (uw.op == OP_FINISH) && out_free;
  assign res.level = lvl;

endmodule

`default_nettype wire

// ===== hw/rtl/eased_brightness_fader.sv =====
// Eased brightness fader top level: command decode, fade state, config registers
// and result register. Depends on ebf_pkg and ebf_tick_engine.
//
// Usage:
//   in_*  : one beat per command. A set beat (command 0) converts percent to a level,
//           cancels any running fade and arms a new one if the level changes; it gives
//           no result. A tick beat (command 1) advances a running fade and gives one
//           result beat; a tick with no fade running is dropped.
//   out_* : level and fade_done of each tick. The result sits in an output register, so
//           the next command is taken while a result still waits.
//   cfg_* : register writes, always ready; index 0 slow duration, 1 fast duration,
//           2 tick period. Other indexes are ignored.
// Ticks: a tick beat registers a start strobe that launches the microcoded engine; the
//   engine runs the divider, one quotient bit per cycle, then the cosine polynomial, ease
//   and blend steps. The final tick of a fade skips the divider. The result goes to the
//   output register when the engine finishes; in_stall stays high until then, so a new
//   tick is not taken while the engine still works on the last one.
// Reset: synchronous; clears the fade state and loads the default durations and tick period.
// Stall: while out_stall holds a result, a finished tick waits in the engine's last step.
`default_nettype none

module eased_brightness_fader
  import ebf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0]  slow_ms_r, slow_ms_nxt;
  logic [15:0]  fast_ms_r, fast_ms_nxt;
  logic [7:0]   tick_ms_r, tick_ms_nxt;
  logic [7:0]   cur_lvl_r, cur_lvl_nxt;
  logic [7:0]   start_lvl_r, start_lvl_nxt;
  logic [7:0]   tgt_lvl_r, tgt_lvl_nxt;
  logic [16:0]  elapsed_r, elapsed_nxt;
  logic [15:0]  dur_r, dur_nxt;
  logic         fading_r, fading_nxt;
  logic         done_r, done_nxt;
  logic         dim_r, dim_nxt;
  logic         start_r, start_nxt;
  logic         out_valid_r, out_valid_nxt;
  out_item_t    out_data_r, out_data_nxt;

  logic         in_acc;
  logic         busy;
  logic         out_free;
  logic [14:0]  pct_scaled;
  logic [30:0]  pct_prod;
  logic [8:0]   pct_lvl;
  logic [7:0]   set_lvl;
  logic [17:0]  elapsed_sum;
  logic [16:0]  elapsed_sat;
  job_t         job;
  eng_res_t     res;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = busy || start_r;
  assign out_free = !out_valid_r || !out_stall;

  assign job.elapsed    = elapsed_r[15:0];
  assign job.dur        = dur_r;
  assign job.start_lvl  = start_lvl_r;
  assign job.target_lvl = tgt_lvl_r;
  assign job.done       = done_r;
  assign job.dim        = dim_r;

  ebf_tick_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .job      (job),
    .out_free (out_free),
    .busy     (busy),
    .res      (res)
  );

  // Percent to level, round to nearest, saturate at 255; elapsed time plus tick period, saturated
  always_comb begin
    pct_scaled = ({in_data.percent, 8'd0} - {8'd0, in_data.percent}) + ROUND_HALF;
    pct_prod   = {16'd0, pct_scaled} * {15'd0, RECIP_100};
    pct_lvl    = pct_prod[RECIP_SHIFT +: 9];
    set_lvl    = pct_lvl[8] ? 8'hFF : pct_lvl[7:0];
    elapsed_sum = {1'b0, elapsed_r} + {10'd0, tick_ms_r};
    elapsed_sat = elapsed_sum[17] ? ELAPSED_MAX : elapsed_sum[16:0];
  end

  // Configuration writes
  always_comb begin
    slow_ms_nxt = slow_ms_r;
    fast_ms_nxt = fast_ms_r;
    tick_ms_nxt = tick_ms_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SLOW_FADE: slow_ms_nxt = cfg_data;
        REG_FAST_FADE: fast_ms_nxt = cfg_data;
        REG_TICK_PER:  tick_ms_nxt = cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Fade state and result register
  always_comb begin
    cur_lvl_nxt   = cur_lvl_r;
    start_lvl_nxt = start_lvl_r;
    tgt_lvl_nxt   = tgt_lvl_r;
    elapsed_nxt   = elapsed_r;
    dur_nxt       = dur_r;
    fading_nxt    = fading_r;
    done_nxt      = done_r;
    dim_nxt       = dim_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (in_acc) begin
      case (in_data.command)
        CMD_SET: begin
          fading_nxt = 1'b0;
          if (set_lvl != cur_lvl_r) begin
            start_lvl_nxt = cur_lvl_r;
            tgt_lvl_nxt   = set_lvl;
            elapsed_nxt   = '0;
            dur_nxt       = in_data.slow ? slow_ms_r : fast_ms_r;
            fading_nxt    = 1'b1;
          end
        end
        CMD_TICK: begin
          if (fading_r) begin
            elapsed_nxt = elapsed_sat;
            done_nxt    = elapsed_sat >= {1'b0, dur_r};
            dim_nxt     = tgt_lvl_r < start_lvl_r;
            start_nxt   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (res.fin) begin
      cur_lvl_nxt            = res.level;
      out_valid_nxt          = 1'b1;
      out_data_nxt.level     = res.level;
      out_data_nxt.fade_done = done_r;
      if (done_r) begin
        fading_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_ms_r   <= 16'd10000;
      fast_ms_r   <= 16'd250;
      tick_ms_r   <= 8'd10;
      cur_lvl_r   <= '0;
      start_lvl_r <= '0;
      tgt_lvl_r   <= '0;
      elapsed_r   <= '0;
      dur_r       <= '0;
      fading_r    <= 1'b0;
      done_r      <= 1'b0;
      dim_r       <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      slow_ms_r   <= slow_ms_nxt;
      fast_ms_r   <= fast_ms_nxt;
      tick_ms_r   <= tick_ms_nxt;
      cur_lvl_r   <= cur_lvl_nxt;
      start_lvl_r <= start_lvl_nxt;
      tgt_lvl_r   <= tgt_lvl_nxt;
      elapsed_r   <= elapsed_nxt;
      dur_r       <= dur_nxt;
      fading_r    <= fading_nxt;
      done_r      <= done_nxt;
      dim_r       <= dim_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
